@@ src/mt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 package
// Shared constants and the operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mt_pkg;

	// Table geometry and the twist recurrence offset.
	localparam int unsigned STATE_WORDS = 624;
	localparam int unsigned ADDR_W      = $clog2(STATE_WORDS);
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned TWIST_WRAP   = STATE_WORDS - TWIST_OFFSET;

	// Read position values with a special meaning.
	localparam logic [ADDR_W-1:0] POS_TWIST_DUE  = ADDR_W'(STATE_WORDS);
	localparam logic [ADDR_W-1:0] POS_NEVER_SEED = ADDR_W'(STATE_WORDS + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(STATE_WORDS - 1);

	// Generator constants.
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] MATRIX_A     = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		UOP_SEED_MUL = 2'd0,
		UOP_SEED_ADD = 2'd1,
		UOP_TWIST    = 2'd2,
		UOP_TEMPER   = 2'd3
	} unit_op_t;

endpackage

@@ src/mt_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 state table
// Word memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mt_table import mt_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [31:0]       rd_data_a,
	output logic [31:0]       rd_data_b
);

	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Both read ports are registered: data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

@@ src/mt_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 arithmetic unit
// Shared datapath for the seed multiply, the seed add, one twist step and
// the output tempering.
// ----------------------------------------------------------------------------
module mt_unit import mt_pkg::*; (
	input  unit_op_t    op,
	input  logic [31:0] opnd_a,
	input  logic [31:0] opnd_b,
	input  logic [31:0] opnd_c,
	output logic [31:0] result
);

	logic [31:0] mixed;
	logic [31:0] product;
	logic [31:0] twist_y;
	logic [31:0] twist_r;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] t3;
	logic [31:0] t4;

	// Seed recurrence multiply, low word of the product only.
	assign mixed   = opnd_a ^ (opnd_a >> 30);
	assign product = 32'(SEED_MULT * mixed);

	// One twist step: high bit of the current word, low bits of the next one.
	assign twist_y = {opnd_a[31], opnd_b[30:0]};
	assign twist_r = opnd_c ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : 32'd0);

	// Output tempering.
	assign t1 = opnd_a ^ (opnd_a >> 11);
	assign t2 = t1 ^ ((t1 << 7) & TEMPER_B);
	assign t3 = t2 ^ ((t2 << 15) & TEMPER_C);
	assign t4 = t3 ^ (t3 >> 18);

	// Operation select.
	always_comb begin
		case (op)
			UOP_SEED_MUL: result = product;
			UOP_SEED_ADD: result = opnd_a + opnd_b;
			UOP_TWIST:    result = twist_r;
			UOP_TEMPER:   result = t4;
			default:      result = 32'd0;
		endcase
	end

endmodule

@@ src/mt19937_word_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 word generator
// Standard 32-bit Mersenne Twister with a sequencer around one shared
// arithmetic unit and a 624-word state table.
// ----------------------------------------------------------------------------
// Channel  Signals                              Direction  Transaction
// s_       s_tvalid s_tready s_tdata s_tuser    in         seed or draw request
// m_       m_tvalid m_tready m_tdata            out        tempered word
// cfg_     cfg_valid cfg_ready cfg_data         in         default seed write
//
// A draw passes the read state and then the output state before its word is
// loaded into the output register, and the next request is taken once the
// sequencer is back in idle. On the single shared unit, a due twist runs first
// (a prime and a load, then per word one table read and one write), and a seed
// pass writes word 0, then a multiply and an add per word. The request channel
// is not ready while an item is in work, and a draw waits while the result
// register is full. Reset clears control state and sets the default seed to
// 5489; the table contents are undefined until the first seed pass.
// ----------------------------------------------------------------------------
module mt19937_word_generator import mt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] seed_value
	input  logic        s_tuser,   // [0] op (0 draw, 1 seed)
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] random_word
	// Default seed register write.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_SD_INIT  = 10'b00_0000_0010,
		ST_SD_MUL   = 10'b00_0000_0100,
		ST_SD_ADD   = 10'b00_0000_1000,
		ST_TW_PRIME = 10'b00_0001_0000,
		ST_TW_LOAD  = 10'b00_0010_0000,
		ST_TW_RD    = 10'b00_0100_0000,
		ST_TW_WR    = 10'b00_1000_0000,
		ST_DR_RD    = 10'b01_0000_0000,
		ST_DR_OUT   = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] idx_q;
	logic [31:0]       seed_q;
	logic [31:0]       prev_q;
	logic [31:0]       acc_q;
	logic [31:0]       cur_q;
	logic              draw_q;
	logic [31:0]       default_seed_q;
	logic              out_valid_q;
	logic [31:0]       out_word_q;

	logic              in_fire;
	logic              out_free;
	logic [ADDR_W-1:0] idx_next;
	logic [ADDR_W-1:0] idx_far;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [31:0]       rd_data_a;
	logic [31:0]       rd_data_b;

	unit_op_t          u_op;
	logic [31:0]       u_a;
	logic [31:0]       u_b;
	logic [31:0]       u_c;
	logic [31:0]       u_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_word_q;

	// Neighbor indexes of the twist step, taken modulo the table size.
	assign idx_next = (idx_q == LAST_ADDR) ? '0 : idx_q + 1'b1;
	assign idx_far  = (idx_q >= ADDR_W'(TWIST_WRAP)) ? idx_q - ADDR_W'(TWIST_WRAP)
	                                                 : idx_q + ADDR_W'(TWIST_OFFSET);

	// Table read addresses.
	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			ST_TW_RD: begin
				rd_addr_a = idx_next;
				rd_addr_b = idx_far;
			end
			ST_DR_RD, ST_DR_OUT: begin
				rd_addr_a = pos_q;
			end
			default: begin
				rd_addr_a = '0;
			end
		endcase
	end

	// Shared unit operands and table writes.
	always_comb begin
		u_op    = UOP_TEMPER;
		u_a     = rd_data_a;
		u_b     = 32'd0;
		u_c     = 32'd0;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = u_res;
		case (state_q)
			ST_SD_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = seed_q;
			end
			ST_SD_MUL: begin
				u_op = UOP_SEED_MUL;
				u_a  = prev_q;
			end
			ST_SD_ADD: begin
				u_op  = UOP_SEED_ADD;
				u_a   = acc_q;
				u_b   = 32'(idx_q);
				wr_en = 1'b1;
			end
			ST_TW_WR: begin
				u_op  = UOP_TWIST;
				u_a   = cur_q;
				u_b   = rd_data_a;
				u_c   = rd_data_b;
				wr_en = 1'b1;
			end
			default: begin
				u_op = UOP_TEMPER;
			end
		endcase
	end

	// Default seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_seed_q <= DEFAULT_SEED;
		end else if (cfg_valid && cfg_ready) begin
			default_seed_q <= cfg_data;
		end
	end

	// Result register valid flag: set when a draw completes, cleared when the
	// transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DR_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= POS_NEVER_SEED;
			idx_q       <= '0;
			draw_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						draw_q <= !s_tuser;
						if (s_tuser) begin
							state_q <= ST_SD_INIT;
						end else if (pos_q == POS_NEVER_SEED) begin
							state_q <= ST_SD_INIT;
						end else if (pos_q == POS_TWIST_DUE) begin
							state_q <= ST_TW_PRIME;
						end else begin
							state_q <= ST_DR_RD;
						end
					end
				end
				ST_SD_INIT: begin
					idx_q   <= ADDR_W'(1);
					state_q <= ST_SD_MUL;
				end
				ST_SD_MUL: begin
					state_q <= ST_SD_ADD;
				end
				ST_SD_ADD: begin
					if (idx_q == LAST_ADDR) begin
						pos_q   <= POS_TWIST_DUE;
						state_q <= draw_q ? ST_TW_PRIME : ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SD_MUL;
					end
				end
				ST_TW_PRIME: begin
					idx_q   <= '0;
					state_q <= ST_TW_LOAD;
				end
				ST_TW_LOAD: begin
					state_q <= ST_TW_RD;
				end
				ST_TW_RD: begin
					state_q <= ST_TW_WR;
				end
				ST_TW_WR: begin
					if (idx_q == LAST_ADDR) begin
						pos_q   <= '0;
						state_q <= ST_DR_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_TW_RD;
					end
				end
				ST_DR_RD: begin
					state_q <= ST_DR_OUT;
				end
				ST_DR_OUT: begin
					if (out_free) begin
						pos_q       <= pos_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			seed_q <= s_tuser ? s_tdata : default_seed_q;
		end
		case (state_q)
			ST_SD_INIT: prev_q <= seed_q;
			ST_SD_MUL:  acc_q  <= u_res;
			ST_SD_ADD:  prev_q <= u_res;
			ST_TW_LOAD: cur_q  <= rd_data_a;
			ST_TW_WR:   cur_q  <= rd_data_a;
			ST_DR_OUT: begin
				if (out_free) begin
					out_word_q <= u_res;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	mt_table u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	mt_unit u_unit (
		.op     (u_op),
		.opnd_a (u_a),
		.opnd_b (u_b),
		.opnd_c (u_c),
		.result (u_res)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 word generator testbench
// Drives seed and draw requests into the generator and checks every tempered
// word against a cycle-free model of the 624-word twister kept in a small
// scoreboard. The run covers a directed opening, the default seed register,
// long draw runs across table twists and four handshake pacing phases.
// ----------------------------------------------------------------------------
module tb_top import mt_pkg::*;;

	// Request kinds carried on s_tuser.
	typedef enum bit {
		OP_DRAW = 1'b0,
		OP_SEED = 1'b1
	} request_op_t;

	localparam logic [31:0] MSB_ONLY      = 32'h8000_0000;
	localparam logic [31:0] LOW_31_BITS   = 32'h7FFF_FFFF;
	localparam int          CYCLE_LIMIT   = 1_000_000;
	localparam int          SETTLE_CYCLES = 1500;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          REPORT_LIMIT  = 10;

	// Expected-word store with its own copy of the generator state.
	class mt_scoreboard;
		bit [31:0]   words [STATE_WORDS];
		int unsigned read_pos;
		bit [31:0]   fallback_seed;
		bit [31:0]   expected_words [$];
		int          errors;
		int          words_checked;
		int          seeds_seen;
		int          twists_seen;

		function new();
			read_pos      = POS_NEVER_SEED;
			fallback_seed = DEFAULT_SEED;
		endfunction

		// Initialization recurrence; leaves a twist due.
		function void fill(bit [31:0] seed);
			bit [31:0] prev;
			words[0] = seed;
			for (int i = 1; i < STATE_WORDS; i++) begin
				prev     = words[i - 1];
				words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
			end
			read_pos = STATE_WORDS;
		endfunction

		// Called for every accepted request transaction.
		function void note_request(request_op_t op, bit [31:0] seed);
			bit [31:0] x;
			bit [31:0] xa;
			bit [31:0] y;
			if (op == OP_SEED) begin
				fill(seed);
				seeds_seen++;
				return;
			end
			if (read_pos >= STATE_WORDS) begin
				if (read_pos > STATE_WORDS)
					fill(fallback_seed);
				for (int i = 0; i < STATE_WORDS; i++) begin
					x  = (words[i] & MSB_ONLY) |
					     (words[(i + 1) % STATE_WORDS] & LOW_31_BITS);
					xa = x >> 1;
					if (x[0])
						xa ^= MATRIX_A;
					words[i] = words[(i + TWIST_OFFSET) % STATE_WORDS] ^ xa;
				end
				read_pos = 0;
				twists_seen++;
			end
			// Tempering of the word at the read position.
			y = words[read_pos];
			y ^= y >> 11;
			y ^= (y << 7) & TEMPER_B;
			y ^= (y << 15) & TEMPER_C;
			y ^= y >> 18;
			expected_words.push_back(y);
			read_pos++;
		endfunction

		// Called for every accepted result transaction.
		function void check_word(bit [31:0] actual);
			bit [31:0] expected;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("[%0t] unexpected word %08h with nothing pending", $time, actual);
				return;
			end
			expected = expected_words.pop_front();
			words_checked++;
			if (actual !== expected) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("[%0t] random_word mismatch: expected %08h, got %08h",
						$time, expected, actual);
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	mt_scoreboard board;
	int  sender_idle_pct    = 0;
	int  receiver_stall_pct = 0;
	int  cycle_count        = 0;
	int  hold_left          = 0;
	bit  hold_req           = 1'b0;
	bit  hold_taken         = 1'b0;
	int  cfg_writes         = 0;

	mt19937_word_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles without finishing.", cycle_count);
		$display("TEST FAILED");
		$finish;
	end

	// Result side: checks each transaction, stalls at random and once holds
	// off for a long stretch so that the request side backs up.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word(m_tdata);
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_request(request_op_t op, logic [31:0] seed);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= seed;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(op, seed);
	endtask

	// Stops offering and waits for every pending word; optionally lets a
	// seed pass or twist still in work run out.
	task automatic settle(bit linger);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_words.size() != 0)
			@(posedge clk);
		if (linger)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_seed(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.fallback_seed = value;
		cfg_writes++;
	endtask

	// Stimulus.
	initial begin
		int          phase_items [4];
		int          sender_pcts [4];
		int          stall_pcts  [4];
		logic [31:0] cfg_values  [4];
		logic [31:0] seed;
		int          pick;

		phase_items = '{640, 300, 300, 300};
		sender_pcts = '{0, 70, 0, 16};
		stall_pcts  = '{0, 0, 70, 16};
		cfg_values  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), DEFAULT_SEED};
		board = new();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: unseeded draws, extreme seeds, back-to-back
		// reseeds and draws with the ignored seed field at its extremes.
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_DRAW, 32'hFFFF_FFFF);
		send_request(OP_SEED, 32'h0000_0000);
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_SEED, 32'hFFFF_FFFF);
		send_request(OP_DRAW, 32'hFFFF_FFFF);
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_SEED, MSB_ONLY);
		send_request(OP_SEED, LOW_31_BITS);
		send_request(OP_DRAW, 32'h5555_5555);
		send_request(OP_SEED, 32'h0000_0001);
		send_request(OP_DRAW, 32'hFFFF_FFFF);
		send_request(OP_DRAW, 32'h0000_0000);
		send_request(OP_SEED, DEFAULT_SEED);
		for (int i = 0; i < 6; i++)
			send_request(OP_DRAW, $urandom());

		for (int phase = 0; phase < 4; phase++) begin
			settle(1'b1);
			write_default_seed(cfg_values[phase]);
			sender_idle_pct    = sender_pcts[phase];
			receiver_stall_pct <= stall_pcts[phase];
			for (int n = 0; n < phase_items[phase]; n++) begin
				if (phase == 0 && n == 320)
					hold_req <= 1'b1;
				if (phase == 2 && n == 150)
					settle(1'b0);
				// Long draw runs with a rare reseed; the first phase never
				// reseeds so that a run crosses a regular table twist.
				pick = $urandom_range(0, 99);
				if (phase != 0 && pick == 0) begin
					case ($urandom_range(0, 3))
						0:       seed = 32'h0000_0000;
						1:       seed = 32'hFFFF_FFFF;
						default: seed = $urandom();
					endcase
					send_request(OP_SEED, seed);
				end else begin
					send_request(OP_DRAW, $urandom());
				end
			end
		end

		settle(1'b1);
		$display("Checked %0d drawn words after %0d seed requests and %0d table twists,",
			board.words_checked, board.seeds_seen, board.twists_seen);
		$display("with %0d default seed writes across four stall and idle pacing phases.",
			cfg_writes);
		board.errors += board.expected_words.size();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
